>>> src/nphc_pkg.sv
// ----------------------------------------------------------------------------
// nphc_pkg
// shared types and constants of the nearest pivot hit counter
// ----------------------------------------------------------------------------
package nphc_pkg;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // input item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOTS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE   = 1'b1;

   localparam logic [4:0] PIVOTS_RESET = 5'd0;
   localparam logic [7:0] DIMS_RESET   = 8'd128;

   // split thresholds per level: fibonacci 1,1,2,3,... saturated to 32 bits
   localparam int unsigned THRESH_DEPTH = 48;
   localparam logic [31:0] THRESH_TABLE [THRESH_DEPTH] = '{
      32'd1, 32'd1, 32'd2, 32'd3, 32'd5, 32'd8, 32'd13, 32'd21,
      32'd34, 32'd55, 32'd89, 32'd144, 32'd233, 32'd377, 32'd610, 32'd987,
      32'd1597, 32'd2584, 32'd4181, 32'd6765, 32'd10946, 32'd17711,
      32'd28657, 32'd46368, 32'd75025, 32'd121393, 32'd196418, 32'd317811,
      32'd514229, 32'd832040, 32'd1346269, 32'd2178309, 32'd3524578,
      32'd5702887, 32'd9227465, 32'd14930352, 32'd24157817, 32'd39088169,
      32'd63245986, 32'd102334155, 32'd165580141, 32'd267914296,
      32'd433494437, 32'd701408733, 32'd1134903170, 32'd1836311903,
      32'd2971215073, 32'd4294967295
   };

endpackage

>>> src/nearest_pivot_hit_counter_core.sv
// ----------------------------------------------------------------------------
// nearest_pivot_hit_counter_core
// nearest pivot search by squared l2 distance with per-pivot hit counters
// ----------------------------------------------------------------------------
// usage:
//   req_ channel: kind 0 transfers load one pivot element into the pivot
//   store, kind 1 transfers write one query element; a query element with
//   last set starts the search over pivots_in_use pivots and dims_in_use
//   elements (csr_ channel, to be written only while idle; the block does not enforce this).
//   rsp_ channel: one transfer per query element with last set, giving the
//   nearest pivot (lowest index on a tie), its split flag and its new level.
// throughput and search steps:
//   loads and non-last query elements are taken one per cycle while idle.
//   a last query element starts a walk that reads one element pair per cycle
//   from the pivot store and query buffer (one read port each) into a
//   subtract / square / accumulate pipe; the finish state then updates the
//   hit counter and loads the result register once that register is free.
//   with no pivots or no dims in use the search skips the walk.
// reset: counters and levels clear, pivots_in_use = 0, dims_in_use = 128;
//   the stores are undefined until written.
// stall: the result register holds until taken; loads and query elements
//   are accepted only while idle, and a finished search waits for the register.
// ----------------------------------------------------------------------------
module nearest_pivot_hit_counter_core #(
   parameter int unsigned MAX_PIVOTS = 16,
   parameter int unsigned MAX_DIMS   = 128,
   parameter int unsigned LEVELS     = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // item transfers
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [3:0]                        req_pivot_index,
   input  logic [6:0]                        req_element_index,
   input  logic signed [15:0]                req_value,
   input  logic                              req_last,
   // result transfers
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [3:0]                        rsp_nearest_index,
   output logic                              rsp_need_split,
   output logic [4:0]                        rsp_new_level,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nphc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nphc_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   // widths derived from the storage size
   localparam int unsigned PW    = (MAX_PIVOTS > 1) ? $clog2(MAX_PIVOTS) : 1;
   localparam int unsigned DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int unsigned NPW   = $clog2(MAX_PIVOTS + 1);
   localparam int unsigned NDW   = $clog2(MAX_DIMS + 1);
   localparam int unsigned DEPTH = MAX_PIVOTS * MAX_DIMS;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LW    = $clog2(LEVELS);
   localparam int unsigned ACC_W = 32 + NDW;

   // pipeline tag that travels with each element pair
   typedef struct packed {
      logic          valid;
      logic          last_e;
      logic          last_p;
      logic [PW-1:0] idx;
   } tag_type;

   nphc_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [4:0] pivots_ff;
   logic [7:0] dims_ff;
   logic [NPW-1:0] np;
   logic [NDW-1:0] nd;

   // memories
   logic [15:0] pivot_mem [DEPTH];
   logic [15:0] query_mem [MAX_DIMS];
   logic [15:0] p_rd_ff, q_rd_ff;

   // walk issue counters
   logic          issue_on_ff;
   logic [PW-1:0] p_ff;
   logic [DW-1:0] e_ff;
   logic [AW-1:0] base_ff;
   logic          issue_last_e, issue_last_p;

   // pipe stages
   tag_type              s1_ff, s2_ff, s3_ff;
   logic signed [16:0]   diff_in, diff_ff;
   logic signed [33:0]   sq_full;
   logic [31:0]          sq_ff;
   logic [ACC_W-1:0]     acc_ff, sum;
   logic [ACC_W-1:0]     best_d_ff;
   logic [PW-1:0]        best_p_ff;
   logic                 none_ff;
   logic                 walk_done;

   // hit counters and levels
   logic [31:0]   hit_ff   [MAX_PIVOTS];
   logic [LW-1:0] level_ff [MAX_PIVOTS];
   logic [31:0]   hit_inc;
   logic [LW-1:0] cur_level, level_in;
   logic          split;

   // result register
   logic       rsp_valid_ff;
   logic [3:0] rsp_idx_ff;
   logic       rsp_split_ff;
   logic [4:0] rsp_level_ff;

   logic req_xfer, start, finish_go;
   logic pivot_ok, query_ok;

   // clamp the configured counts to the storage size
   assign np = (32'(pivots_ff) > MAX_PIVOTS) ? NPW'(MAX_PIVOTS) : NPW'(pivots_ff);
   assign nd = (32'(dims_ff) > MAX_DIMS) ? NDW'(MAX_DIMS) : NDW'(dims_ff);

   assign req_xfer = req_valid && req_ready;
   assign start    = req_xfer && (req_kind == nphc_pkg::KIND_QUERY) && req_last;
   assign pivot_ok = (32'(req_pivot_index) < MAX_PIVOTS) &&
                     (32'(req_element_index) < MAX_DIMS);
   assign query_ok = 32'(req_element_index) < MAX_DIMS;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pivots_ff <= nphc_pkg::PIVOTS_RESET;
         dims_ff   <= nphc_pkg::DIMS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            nphc_pkg::CSR_PIVOTS_IN_USE: pivots_ff <= csr_wdata[4:0];
            nphc_pkg::CSR_DIMS_IN_USE:   dims_ff   <= csr_wdata[7:0];
         endcase
      end
   end

   // -------------------------------------------------------------- memories
   // loads write the pivot store, query elements the query buffer; the walk
   // reads both through registered read ports
   always_ff @(posedge clock) begin
      if (req_xfer && (req_kind == nphc_pkg::KIND_LOAD) && pivot_ok) begin
         pivot_mem[AW'(32'(req_pivot_index) * MAX_DIMS + 32'(req_element_index))]
            <= req_value;
      end
      p_rd_ff <= pivot_mem[base_ff + AW'(e_ff)];
   end

   always_ff @(posedge clock) begin
      if (req_xfer && (req_kind == nphc_pkg::KIND_QUERY) && query_ok) begin
         query_mem[DW'(req_element_index)] <= req_value;
      end
      q_rd_ff <= query_mem[e_ff];
   end

   // ------------------------------------------------------------ walk issue
   assign issue_last_e = (NDW'(e_ff) + NDW'(1)) == nd;
   assign issue_last_p = (NPW'(p_ff) + NPW'(1)) == np;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_on_ff <= 1'b0;
      end else if (start && (np != '0) && (nd != '0)) begin
         issue_on_ff <= 1'b1;
      end else if (issue_on_ff && issue_last_e && issue_last_p) begin
         issue_on_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         p_ff    <= '0;
         e_ff    <= '0;
         base_ff <= '0;
      end else if (issue_on_ff) begin
         if (issue_last_e) begin
            e_ff    <= '0;
            p_ff    <= p_ff + PW'(1);
            base_ff <= base_ff + AW'(MAX_DIMS);
         end else begin
            e_ff <= e_ff + DW'(1);
         end
      end
   end

   // ------------------------------------------------ subtract, square, sum
   assign diff_in = $signed({q_rd_ff[15], q_rd_ff}) - $signed({p_rd_ff[15], p_rd_ff});
   assign sq_full = diff_ff * diff_ff;
   assign sum     = acc_ff + ACC_W'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= '{valid: issue_on_ff, last_e: issue_last_e,
                    last_p: issue_last_p, idx: p_ff};
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= sq_full[31:0];
   end

   // distance of a pivot is complete on its last element; strict compare
   // keeps the lowest index on a tie
   assign walk_done = s3_ff.valid && s3_ff.last_e && s3_ff.last_p;

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         best_p_ff <= '0;
         none_ff   <= (np == '0);
      end else if (s3_ff.valid) begin
         if (s3_ff.last_e) begin
            acc_ff <= '0;
            if ((s3_ff.idx == '0) || (sum < best_d_ff)) begin
               best_d_ff <= sum;
               best_p_ff <= s3_ff.idx;
            end
         end else begin
            acc_ff <= sum;
         end
      end
   end

   // ------------------------------------------------------------- sequencer
   assign finish_go = (state_ff == nphc_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nphc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         nphc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (start) begin
               if ((np == '0) || (nd == '0)) begin
                  state_in = nphc_pkg::ST_FINISH;
               end else begin
                  state_in = nphc_pkg::ST_WALK;
               end
            end
         end
         nphc_pkg::ST_WALK: begin
            if (walk_done) begin
               state_in = nphc_pkg::ST_FINISH;
            end
         end
         nphc_pkg::ST_FINISH: begin
            if (finish_go) begin
               state_in = nphc_pkg::ST_IDLE;
            end
         end
         default: state_in = nphc_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------- hit counter update
   assign cur_level = level_ff[best_p_ff];
   assign hit_inc   = hit_ff[best_p_ff] + 32'd1;
   assign split     = hit_inc >= nphc_pkg::THRESH_TABLE[6'(cur_level)];
   assign level_in  = (split && (32'(cur_level) < LEVELS - 1)) ?
                      cur_level + LW'(1) : cur_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PIVOTS; i++) begin
            hit_ff[i]   <= '0;
            level_ff[i] <= '0;
         end
      end else if (finish_go && !none_ff) begin
         hit_ff[best_p_ff]   <= split ? 32'd0 : hit_inc;
         level_ff[best_p_ff] <= level_in;
      end
   end

   // --------------------------------------------------------------- results
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         if (none_ff) begin
            rsp_idx_ff   <= '0;
            rsp_split_ff <= 1'b0;
            rsp_level_ff <= '0;
         end else begin
            rsp_idx_ff   <= 4'(best_p_ff);
            rsp_split_ff <= split;
            rsp_level_ff <= 5'(level_in);
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;
   assign rsp_need_split    = rsp_split_ff;
   assign rsp_new_level     = rsp_level_ff;

   // ------------------------------------------------------------ assertions
   // a split always lifts the level off zero
   a_split_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_need_split |-> rsp_new_level != '0)
      else $error("split reported with level zero");

   // the walk only issues reads inside its own state
   a_issue_walk: assert property (@(posedge clock) disable iff (reset)
      issue_on_ff |-> state_ff == nphc_pkg::ST_WALK)
      else $error("walk issue outside walk state");

   // the chosen pivot lies within the pivots searched
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nphc_pkg::ST_FINISH) && !none_ff |->
         (NPW'(best_p_ff) < np) || (nd == '0))
      else $error("nearest pivot outside searched range");

   // the end of a walk moves the sequencer to the counter update
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      walk_done |=> state_ff == nphc_pkg::ST_FINISH)
      else $error("walk end not followed by update");

endmodule

>>> verif/nphc_checker.sv
// ----------------------------------------------------------------------------
// nphc_checker
// watches the item, result and register channels of the nearest pivot hit
// counter, predicts each search result and compares it with what comes out
// ----------------------------------------------------------------------------
module nphc_checker #(
   parameter int unsigned MAX_PIVOTS = 16,
   parameter int unsigned MAX_DIMS   = 128,
   parameter int unsigned LEVELS     = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_kind,
   input  logic [3:0]                     req_pivot_index,
   input  logic [6:0]                     req_element_index,
   input  logic signed [15:0]             req_value,
   input  logic                           req_last,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [3:0]                     rsp_nearest_index,
   input  logic                           rsp_need_split,
   input  logic [4:0]                     rsp_new_level,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [nphc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nphc_pkg::CSR_DAT_W-1:0] csr_wdata,
   output int unsigned                    error_count,
   output int unsigned                    results_due,
   output int unsigned                    results_seen,
   output int unsigned                    splits_seen,
   output int unsigned                    deepest_level
);
   import nphc_pkg::*;

   typedef struct packed {
      logic [3:0] nearest;
      logic       split;
      logic [4:0] level;
   } pivot_hit_t;

   logic [15:0] pivot_mem [MAX_PIVOTS][MAX_DIMS];
   logic [15:0] query_mem [MAX_DIMS];
   logic [31:0] hit_count [MAX_PIVOTS];
   int unsigned pivot_level [MAX_PIVOTS];
   logic [4:0]  pivots_cfg;
   logic [7:0]  dims_cfg;
   pivot_hit_t  nearest_due [$];

   // fibonacci split threshold of a level, saturated to 32 bits
   function automatic logic [31:0] fib_limit(int unsigned lvl);
      longint unsigned a, b, t;
      int unsigned i;
      a = 1;
      b = 1;
      for (i = 0; i < lvl; i++) begin
         t = a;
         a = b;
         b = t + b;
         if (b > 64'h1_0000_0000) b = 64'h1_0000_0000;
      end
      return (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
   endfunction

   // exact squared l2 distance between the query and one pivot
   function automatic longint unsigned pivot_distance(int unsigned p, int unsigned nd);
      longint unsigned acc;
      longint          diff;
      logic signed [15:0] qv, pv;
      int unsigned e;
      acc = 0;
      for (e = 0; e < nd; e++) begin
         qv = query_mem[e];
         pv = pivot_mem[p][e];
         diff = qv;
         diff = diff - pv;
         acc = acc + diff * diff;
      end
      return acc;
   endfunction

   // search, then bump the winner's hit count and level
   task automatic predict_nearest(output pivot_hit_t res);
      int unsigned np, nd, best, p;
      longint unsigned best_d, d;
      np = (pivots_cfg > MAX_PIVOTS) ? MAX_PIVOTS : pivots_cfg;
      nd = (dims_cfg > MAX_DIMS) ? MAX_DIMS : dims_cfg;
      res = '0;
      if (np == 0) return;
      best = 0;
      best_d = pivot_distance(0, nd);
      for (p = 1; p < np; p++) begin
         d = pivot_distance(p, nd);
         if (d < best_d) begin
            best_d = d;
            best = p;
         end
      end
      hit_count[best] = hit_count[best] + 32'd1;
      if (hit_count[best] >= fib_limit(pivot_level[best])) begin
         hit_count[best] = '0;
         if (pivot_level[best] < LEVELS - 1) pivot_level[best]++;
         res.split = 1'b1;
      end
      res.nearest = best[3:0];
      res.level = pivot_level[best][4:0];
   endtask

   always @(posedge clock) begin
      pivot_hit_t want, got;
      int unsigned p, e;
      if (reset) begin
         for (p = 0; p < MAX_PIVOTS; p++) begin
            hit_count[p] = '0;
            pivot_level[p] = 0;
            for (e = 0; e < MAX_DIMS; e++) pivot_mem[p][e] = '0;
         end
         for (e = 0; e < MAX_DIMS; e++) query_mem[e] = '0;
         pivots_cfg = PIVOTS_RESET;
         dims_cfg = DIMS_RESET;
         nearest_due.delete();
         error_count = 0;
         results_seen = 0;
         splits_seen = 0;
         deepest_level = 0;
      end else begin
         // results first, so a same-edge search never pairs with this transfer
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_nearest_index, rsp_need_split, rsp_new_level};
            if (nearest_due.size() == 0) begin
               error_count++;
               $display("%0t: result with none expected: nearest %0d split %0d level %0d",
                        $time, got.nearest, got.split, got.level);
            end else begin
               want = nearest_due.pop_front();
               results_seen++;
               if (got != want) begin
                  error_count++;
                  $display("%0t: mismatch: expected nearest %0d split %0d level %0d, got nearest %0d split %0d level %0d",
                           $time, want.nearest, want.split, want.level,
                           got.nearest, got.split, got.level);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PIVOTS_IN_USE) pivots_cfg = csr_wdata[4:0];
            else if (csr_index == CSR_DIMS_IN_USE) dims_cfg = csr_wdata[7:0];
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               if (req_pivot_index < MAX_PIVOTS && req_element_index < MAX_DIMS)
                  pivot_mem[req_pivot_index][req_element_index] = req_value;
            end else begin
               if (req_element_index < MAX_DIMS) query_mem[req_element_index] = req_value;
               if (req_last) begin
                  predict_nearest(want);
                  nearest_due.push_back(want);
                  if (want.split) splits_seen++;
                  if (want.level > deepest_level) deepest_level = want.level;
               end
            end
         end
      end
      results_due = nearest_due.size();
   end

endmodule

>>> verif/tb_nearest_pivot_hit_counter_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_pivot_hit_counter_core
// drives pivot loads, query vectors and register writes into the nearest
// pivot hit counter with random idling on both sides; the checker beside
// the block predicts every search result and counts mismatches
// ----------------------------------------------------------------------------
module tb_nearest_pivot_hit_counter_core;
   import nphc_pkg::*;

   localparam int unsigned PIVOTS      = 16;
   localparam int unsigned DIMS        = 128;
   localparam int unsigned ITEM_GOAL   = 850;     // random transfers to send
   localparam int unsigned HOLD_CYCLES = 1500;    // long result back-pressure
   localparam int unsigned SETTLE      = 4;       // quiet cycles before a csr write
   localparam int unsigned DRAIN_TAIL  = 20;      // extra cycles at the end
   localparam int unsigned LIMIT       = 600000;  // cycle budget of the run

   logic clock = 1'b0;
   logic reset;

   logic                 req_valid;
   logic                 req_ready;
   logic                 req_kind;
   logic [3:0]           req_pivot_index;
   logic [6:0]           req_element_index;
   logic signed [15:0]   req_value;
   logic                 req_last;

   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [3:0]           rsp_nearest_index;
   logic                 rsp_need_split;
   logic [4:0]           rsp_new_level;

   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   int unsigned error_count, results_due, results_seen, splits_seen, deepest_level;

   // stimulus-side view of what has been loaded, used to shape queries and
   // to keep every search away from store entries that were never written
   logic [15:0] pivot_copy [PIVOTS][DIMS];
   bit          pivot_loaded [PIVOTS][DIMS];
   bit          query_loaded [DIMS];
   int unsigned np_eff = 0;       // pivots searched under the current setting
   int unsigned nd_eff = DIMS;    // elements compared under the current setting
   int unsigned fav_pivot = 0;    // pivot that most queries cluster around
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   bit          steady_send = 1'b0;
   bit          hold_results = 1'b0;  // set by stimulus, cleared by the receiver

   always #6 clock = ~clock;

   nearest_pivot_hit_counter_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pivot_index   (req_pivot_index),
      .req_element_index (req_element_index),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_need_split    (rsp_need_split),
      .rsp_new_level     (rsp_new_level),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   nphc_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pivot_index   (req_pivot_index),
      .req_element_index (req_element_index),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_need_split    (rsp_need_split),
      .rsp_new_level     (rsp_new_level),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .error_count       (error_count),
      .results_due       (results_due),
      .results_seen      (results_seen),
      .splits_seen       (splits_seen),
      .deepest_level     (deepest_level)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("nearest_pivot_hit_counter_core regression: fail");
         $finish;
      end
   end

   // idle stretch length: mostly a few cycles, now and then a long one
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // element value: full-scale extremes show up often, otherwise any value
   function automatic logic [15:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h7FFF;
      if (r == 1) return 16'h8000;
      return $urandom;
   endfunction

   // one transfer on the item channel; entered and left at a falling edge
   task automatic send_item(input logic kind, input logic [3:0] pidx,
                            input logic [6:0] eidx, input logic [15:0] value,
                            input logic last);
      int unsigned gap;
      gap = (!steady_send && $urandom_range(0, 3) == 0) ? idle_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_pivot_index   <= pidx;
      req_element_index <= eidx;
      req_value         <= value;
      req_last          <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (kind == KIND_LOAD) begin
         pivot_copy[pidx][eidx] = value;
         pivot_loaded[pidx][eidx] = 1'b1;
      end else begin
         query_loaded[eidx] = 1'b1;
      end
      items_sent++;
   endtask

   // sender goes quiet until every predicted result has been taken
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
   endtask

   // register write, only with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      pause_until_drained();
      repeat (SETTLE) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int unsigned np_raw, input int unsigned nd_raw);
      logic [7:0] w;
      // unused upper bits of the pivot count get random junk
      w = $urandom;
      w[4:0] = np_raw[4:0];
      write_reg(CSR_PIVOTS_IN_USE, w);
      write_reg(CSR_DIMS_IN_USE, nd_raw[7:0]);
      np_eff = (np_raw[4:0] > PIVOTS) ? PIVOTS : np_raw[4:0];
      nd_eff = (nd_raw[7:0] > DIMS) ? DIMS : nd_raw[7:0];
   endtask

   // load every pivot element that the next search will read; some entries
   // copy the previous pivot so that equal distances come up
   task automatic fill_pivots();
      int unsigned p, e;
      logic [15:0] v;
      for (p = 0; p < np_eff; p++)
         for (e = 0; e < nd_eff; e++)
            if (!pivot_loaded[p][e]) begin
               if (p > 0 && pivot_loaded[p-1][e] && $urandom_range(0, 3) == 0)
                  v = pivot_copy[p-1][e];
               else
                  v = pick_value();
               send_item(KIND_LOAD, p[3:0], e[6:0], v, $urandom_range(0, 1));
            end
   endtask

   // one query vector ending in a last element; most queries sit close to
   // the favored pivot so hit counts climb through several levels
   task automatic run_query();
      int unsigned order [$];
      int unsigned i, j, tmp, nz, count;
      bit near;
      logic [15:0] v;
      if (np_eff == 0 || nd_eff == 0) begin
         // no store reads happen here, any element index will do
         count = $urandom_range(1, 2);
         for (i = 0; i < count; i++)
            send_item(KIND_QUERY, $urandom_range(0, 15), $urandom_range(0, 127),
                      $urandom, i == count - 1);
         return;
      end
      if ($urandom_range(0, 9) == 0) fav_pivot = $urandom_range(0, np_eff - 1);
      near = ($urandom_range(0, 3) != 0);
      // near queries rewrite the whole vector, others only a random subset,
      // but an element never written yet is always included
      for (i = 0; i < nd_eff; i++)
         if (near || !query_loaded[i] || $urandom_range(0, 3) == 0) order.push_back(i);
      if (order.size() == 0) order.push_back($urandom_range(0, nd_eff - 1));
      for (i = order.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (i = 0; i < order.size(); i++) begin
         // noise: stray loads and stray query elements in the middle
         if ($urandom_range(0, 9) == 0)
            send_item(KIND_LOAD, $urandom_range(0, 15), $urandom_range(0, 127),
                      $urandom, $urandom_range(0, 1));
         else if ($urandom_range(0, 9) == 0)
            send_item(KIND_QUERY, $urandom_range(0, 15), $urandom_range(0, 127),
                      $urandom, 1'b0);
         if (near) begin
            nz = $urandom_range(0, 4);
            v = pivot_copy[fav_pivot][order[i]] + nz[15:0] - 16'd2;
         end else begin
            v = pick_value();
         end
         send_item(KIND_QUERY, $urandom_range(0, 15), order[i][6:0], v,
                   i == order.size() - 1);
      end
   endtask

   // result side: random stalls, calm stretches, and one long hold-off
   initial begin : result_side
      int unsigned stall;
      bit steady;
      stall = 0;
      steady = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_results) begin
            // results back up, the block must stall its item channel
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
         end else if (stall != 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall = idle_len();
         end
         if ($urandom_range(0, 299) == 0) steady = !steady;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned rand_start, phase, budget, q, n, r, p, e, np_raw, nd_raw;
      bit hold_done;
      hold_done         = 1'b0;
      req_valid         = 1'b0;
      req_kind          = KIND_LOAD;
      req_pivot_index   = '0;
      req_element_index = '0;
      req_value         = '0;
      req_last          = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_PIVOTS_IN_USE;
      csr_wdata         = '0;
      reset             = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // out-of-reset: no pivots in use, so a search reports pivot 0 and no
      // split; a last mark on a load does nothing
      send_item(KIND_LOAD, 4'd15, 7'd127, 16'h7FFF, 1'b1);
      send_item(KIND_QUERY, 4'd0, 7'd127, 16'h8000, 1'b1);
      // two equal pivots against the far extreme: tie goes to the lower index
      set_config(2, 1);
      send_item(KIND_LOAD, 4'd0, 7'd0, 16'h7FFF, 1'b0);
      send_item(KIND_LOAD, 4'd1, 7'd0, 16'h7FFF, 1'b0);
      send_item(KIND_QUERY, 4'd0, 7'd0, 16'h8000, 1'b1);
      // pivot 1 becomes exact match; repeated hits walk it up the levels
      send_item(KIND_LOAD, 4'd1, 7'd0, 16'h8000, 1'b0);
      repeat (4) send_item(KIND_QUERY, 4'd0, 7'd0, 16'h8000, 1'b1);
      send_item(KIND_QUERY, 4'd9, 7'd3, 16'h1234, 1'b0);
      // zero dims: every distance is zero, pivot 0 wins
      set_config(2, 0);
      send_item(KIND_QUERY, 4'd0, 7'd9, 16'h0000, 1'b1);
      // pivot count beyond the table size, still with zero dims
      set_config(31, 0);
      send_item(KIND_QUERY, 4'd3, 7'd64, 16'h00FF, 1'b1);

      // ---- random part: phases of register settings, each with queries ----
      rand_start = items_sent;
      phase = 0;
      while (items_sent - rand_start < ITEM_GOAL) begin
         case (phase)
            0: set_config(16, 2);      // every pivot in use
            1: set_config(1, 255);     // dims beyond the vector length
            2: set_config(0, 6);       // nothing to search
            3: set_config(31, 1);      // pivot count beyond the table
            default: begin
               r = $urandom_range(0, 19);
               np_raw = (r < 2) ? 0 : (r < 4) ? $urandom_range(17, 31) : $urandom_range(1, 16);
               r = $urandom_range(0, 19);
               nd_raw = (r == 0) ? 0 : (r < 3) ? $urandom_range(9, 24) : $urandom_range(1, 8);
               set_config(np_raw, nd_raw);
            end
         endcase
         fav_pivot = (np_eff == 0) ? 0 : $urandom_range(0, np_eff - 1);
         steady_send = ($urandom_range(0, 4) == 0);
         // halfway through, starve the result channel while items keep coming
         if (!hold_done && items_sent - rand_start >= ITEM_GOAL / 2) begin
            hold_results = 1'b1;
            hold_done = 1'b1;
         end
         // full-length vectors are slow, so only a couple of queries there
         budget = (nd_eff > 24) ? 2 : $urandom_range(12, 30);
         for (q = 0; q < budget; q++) begin
            n = $urandom_range(0, 2);
            repeat (n)
               send_item(KIND_LOAD, $urandom_range(0, 15), $urandom_range(0, 127),
                         pick_value(), $urandom_range(0, 1));
            fill_pivots();
            // now and then clone a pivot from its neighbor for a tie
            if (np_eff > 1 && $urandom_range(0, 14) == 0) begin
               p = $urandom_range(1, np_eff - 1);
               for (e = 0; e < nd_eff; e++)
                  send_item(KIND_LOAD, p[3:0], e[6:0], pivot_copy[p-1][e], 1'b0);
            end
            if ($urandom_range(0, 24) == 0) pause_until_drained();
            run_query();
         end
         phase++;
      end

      pause_until_drained();
      repeat (DRAIN_TAIL) @(negedge clock);
      $display("sent %0d item transfers over %0d register phases, checked %0d results",
               items_sent, phase, results_seen);
      $display("split flags predicted: %0d, highest pivot level reached: %0d",
               splits_seen, deepest_level);
      if (error_count == 0 && results_due == 0) begin
         $display("nearest_pivot_hit_counter_core regression: pass");
      end else begin
         $display("nearest_pivot_hit_counter_core regression: fail");
      end
      $finish;
   end

endmodule
